FILE: design/gcr_pkg.sv
// Shared constants, codes and types for the gamma curve resampler.
package gcr_pkg;

  localparam int MAX_POINTS      = 256;
  localparam int MAX_LUT_ENTRIES = 4096;

  localparam int LEVEL_W  = 16;
  localparam int PIDX_W   = $clog2(MAX_POINTS);
  localparam int EIDX_W   = $clog2(MAX_LUT_ENTRIES);
  localparam int SIZE_W   = 13;
  localparam int COUNT_W  = 9;
  localparam int DEN_W    = EIDX_W;
  localparam int DIV_NUM_W = LEVEL_W + DEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int STATUS_W = 2;
  localparam int POINT_W  = 3 * LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hffff;

  localparam logic REG_LUT_SIZE    = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_POINTS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDX_ERR   = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
  } gcr_mix_ctl_t;

endpackage

FILE: design/gcr_div.sv
// Restoring divider, one quotient bit per cycle.
module gcr_div import gcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo,
  output logic [DEN_W-1:0]     rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0]     acc_r, acc_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W:0]       trial;

  assign trial = {acc_r, q_r[DIV_NUM_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      acc_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      if (trial >= {1'b0, den_r}) begin
        acc_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        acc_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = acc_r;

endmodule

FILE: design/gcr_lane.sv
// One colour channel lane: weighted blend of two points, then divide by den.
module gcr_lane import gcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  gcr_mix_ctl_t       ctl,
  input  logic [LEVEL_W-1:0] lo_val,
  input  logic [LEVEL_W-1:0] hi_val,
  output logic               done,
  output logic [LEVEL_W-1:0] level
);

  logic [DIV_NUM_W-1:0] prod_lo_r, prod_hi_r;
  logic [DEN_W-1:0]     den_r;
  logic                 go_r;
  logic [DEN_W-1:0]     wgt_lo;
  logic [DIV_NUM_W:0]   sum;
  logic [DIV_NUM_W-1:0] quo;
  logic [DEN_W-1:0]     rem_unused;

  assign wgt_lo = DEN_W'(ctl.den - ctl.rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= ctl.start;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod_lo_r <= DIV_NUM_W'(lo_val) * DIV_NUM_W'(wgt_lo);
      prod_hi_r <= DIV_NUM_W'(hi_val) * DIV_NUM_W'(ctl.rem);
      den_r     <= ctl.den;
    end
  end

  // the blend never exceeds full scale times den, so it fits the dividend
  assign sum = {1'b0, prod_lo_r} + {1'b0, prod_hi_r};

  gcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .num   (sum[DIV_NUM_W-1:0]),
    .den   (den_r),
    .done  (done),
    .quo   (quo),
    .rem   (rem_unused)
  );

  assign level = (quo > DIV_NUM_W'(FULL_SCALE)) ? FULL_SCALE : quo[LEVEL_W-1:0];

endmodule

FILE: design/gamma_curve_resampler_unit.sv
// Top level: curve point store, index division, three channel lanes and result merge.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------------
//  input   | in_tvalid/in_tready            | tuser func, tdata point/entry fields
//  result  | out_tvalid/out_tready          | tuser status, tdata red/green/blue
//  config  | cfg_we/cfg_addr/cfg_wdata      | lut_size (0), point_count (1)
//
// A write item is taken in S_IDLE and leaves the block idle. A read that hits an error
// goes straight to S_OUT, which loads the output register; a normal read passes S_IDIV
// (index divider, skipped for a one-entry table), S_RD (point store read), S_MIX
// (blend), S_LDIV (lane dividers) and S_OUT. One item is in work at a time; the next is
// taken once the block is back in S_IDLE. Reset is synchronous and clears control state
// only; the point store comes up undefined. A stalled output holds the result.
module gamma_curve_resampler_unit import gcr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,  // point_index, point_red, point_green,
                                         // point_blue, entry_index, zero pad
  input  logic                in_tuser,  // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata, // red_level, green_level, blue_level
  output logic [STATUS_W-1:0] out_tuser, // status
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [SIZE_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_IDIV, S_RD, S_MIX, S_LDIV, S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [SIZE_W-1:0]     lut_size_r, lut_size_nxt;
  logic [COUNT_W-1:0]    point_count_r, point_count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [PIDX_W-1:0]     addr_lo_r, addr_lo_nxt, addr_hi_r, addr_hi_nxt;
  logic [DEN_W-1:0]      rem_r, rem_nxt, den_r, den_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0]    res_red_r, res_red_nxt;
  logic [LEVEL_W-1:0]    res_green_r, res_green_nxt;
  logic [LEVEL_W-1:0]    res_blue_r, res_blue_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [47:0]           out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic [POINT_W-1:0]    curve_mem [MAX_POINTS];
  logic [POINT_W-1:0]    pt_lo_r, pt_hi_r;

  logic [PIDX_W-1:0]     in_point_index;
  logic [POINT_W-1:0]    in_point;
  logic [EIDX_W-1:0]     in_entry_index;
  logic                  accept, mem_we;

  logic [SIZE_W-1:0]     size_eff;
  logic [COUNT_W-1:0]    count_eff;
  logic [SIZE_W-1:0]     den_full;
  logic [PIDX_W-1:0]     count_m1;
  logic [DIV_NUM_W-1:0]  idx_num;
  logic                  idx_start, idx_done;
  logic [DIV_NUM_W-1:0]  idx_quo;
  logic [DEN_W-1:0]      idx_rem;
  logic [PIDX_W-1:0]     w_sel;
  logic [COUNT_W-1:0]    w_next;

  gcr_mix_ctl_t          mix_ctl;
  logic                  lane_done_r, lane_done_g, lane_done_b;
  logic [LEVEL_W-1:0]    lvl_r, lvl_g, lvl_b;

  assign in_point_index = in_tdata[7:0];
  assign in_point       = in_tdata[55:8];
  assign in_entry_index = in_tdata[67:56];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign mem_we    = accept && (in_tuser == FUNC_WRITE);

  assign size_eff  = (lut_size_r > SIZE_W'(MAX_LUT_ENTRIES)) ? SIZE_W'(MAX_LUT_ENTRIES)
                                                             : lut_size_r;
  assign count_eff = (point_count_r > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS)
                                                            : point_count_r;
  assign den_full  = SIZE_W'(size_eff - 1'b1);
  assign count_m1  = PIDX_W'(count_eff - 1'b1);
  assign idx_num   = DIV_NUM_W'(count_m1 * in_entry_index);

  // clamp the whole part to the last point, step to the next one on a remainder
  assign w_sel  = (idx_quo >= DIV_NUM_W'(cnt_r)) ? PIDX_W'(cnt_r - 1'b1)
                                                 : idx_quo[PIDX_W-1:0];
  assign w_next = COUNT_W'({1'b0, w_sel} + 1'b1);

  always_comb begin
    state_nxt       = state_r;
    lut_size_nxt    = lut_size_r;
    point_count_nxt = point_count_r;
    out_valid_nxt   = out_valid_r;
    addr_lo_nxt     = addr_lo_r;
    addr_hi_nxt     = addr_hi_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    cnt_nxt         = cnt_r;
    res_red_nxt     = res_red_r;
    res_green_nxt   = res_green_r;
    res_blue_nxt    = res_blue_r;
    res_status_nxt  = res_status_r;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    idx_start       = 1'b0;
    mix_ctl.start   = 1'b0;
    mix_ctl.rem     = rem_r;
    mix_ctl.den     = den_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_LUT_SIZE:    lut_size_nxt    = cfg_wdata;
        REG_POINT_COUNT: point_count_nxt = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_tuser == FUNC_READ)) begin
          res_red_nxt    = '0;
          res_green_nxt  = '0;
          res_blue_nxt   = '0;
          res_status_nxt = ST_OK;
          cnt_nxt        = count_eff;
          if (count_eff == '0) begin
            res_status_nxt = ST_NO_POINTS;
            state_nxt      = S_OUT;
          end else if (SIZE_W'(in_entry_index) >= size_eff) begin
            res_status_nxt = ST_IDX_ERR;
            state_nxt      = S_OUT;
          end else if (den_full == '0) begin
            // single-entry table: point zero passes unchanged
            addr_lo_nxt = '0;
            addr_hi_nxt = '0;
            rem_nxt     = '0;
            den_nxt     = DEN_W'(1);
            state_nxt   = S_RD;
          end else begin
            den_nxt   = den_full[DEN_W-1:0];
            idx_start = 1'b1;
            state_nxt = S_IDIV;
          end
        end
      end
      S_IDIV: begin
        if (idx_done) begin
          addr_lo_nxt = w_sel;
          addr_hi_nxt = ((idx_rem != '0) && (w_next < cnt_r)) ? w_next[PIDX_W-1:0] : w_sel;
          rem_nxt     = idx_rem;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MIX;
      end
      S_MIX: begin
        mix_ctl.start = 1'b1;
        state_nxt     = S_LDIV;
      end
      S_LDIV: begin
        if (lane_done_r && lane_done_g && lane_done_b) begin
          res_red_nxt   = lvl_r;
          res_green_nxt = lvl_g;
          res_blue_nxt  = lvl_b;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt   = {res_blue_r, res_green_r, res_red_r};
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      lut_size_r    <= SIZE_W'(256);
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      lut_size_r    <= lut_size_nxt;
      point_count_r <= point_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_lo_r    <= addr_lo_nxt;
    addr_hi_r    <= addr_hi_nxt;
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    cnt_r        <= cnt_nxt;
    res_red_r    <= res_red_nxt;
    res_green_r  <= res_green_nxt;
    res_blue_r   <= res_blue_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // point store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      curve_mem[in_point_index] <= in_point;
    end
    pt_lo_r <= curve_mem[addr_lo_r];
    pt_hi_r <= curve_mem[addr_hi_r];
  end

  gcr_div u_idx_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .num   (idx_num),
    .den   (den_full[DEN_W-1:0]),
    .done  (idx_done),
    .quo   (idx_quo),
    .rem   (idx_rem)
  );

  gcr_lane u_lane_red (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mix_ctl),
    .lo_val (pt_lo_r[15:0]),
    .hi_val (pt_hi_r[15:0]),
    .done   (lane_done_r),
    .level  (lvl_r)
  );

  gcr_lane u_lane_green (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mix_ctl),
    .lo_val (pt_lo_r[31:16]),
    .hi_val (pt_hi_r[31:16]),
    .done   (lane_done_g),
    .level  (lvl_g)
  );

  gcr_lane u_lane_blue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mix_ctl),
    .lo_val (pt_lo_r[47:32]),
    .hi_val (pt_hi_r[47:32]),
    .done   (lane_done_b),
    .level  (lvl_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the gamma curve resampler: directed rows, then random phases.
module tb;
  import gcr_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  blue;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  red;
  } gamma_entry_t;

  typedef enum logic [1:0] {ROW_SET_REG, ROW_WRITE, ROW_READ} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               reg_sel;
    logic [SIZE_W-1:0]  reg_val;
    logic [PIDX_W-1:0]  pidx;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [EIDX_W-1:0]  eidx;
    bit                 typed;
    gamma_entry_t       want;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [71:0]         in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [47:0]         out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                cfg_we     = 1'b0;
  logic                cfg_addr   = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata  = '0;

  // Predictor state: curve store, which points are set, and the registers
  logic [POINT_W-1:0]  curve_mem [MAX_POINTS];
  bit                  curve_set [MAX_POINTS];
  logic [SIZE_W-1:0]   lut_reg   = 13'd256;
  logic [COUNT_W-1:0]  count_reg = '0;

  gamma_entry_t        entry_q [$];
  stim_row_t           plan [$];

  int  cycle_cnt    = 0;
  int  fault_cnt    = 0;
  int  n_sent       = 0;
  int  rx_wait      = 0;
  bit  rx_hold      = 1'b0;
  bit  calm         = 1'b0;

  gamma_curve_resampler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_size();
    return (lut_reg > MAX_LUT_ENTRIES) ? MAX_LUT_ENTRIES : lut_reg;
  endfunction

  function automatic int unsigned eff_count();
    return (count_reg > MAX_POINTS) ? MAX_POINTS : count_reg;
  endfunction

  // Find the pair of points an entry blends; zero when no point is read
  function automatic bit locate_points(input logic [EIDX_W-1:0] idx,
                                       output int unsigned w, output int unsigned w2,
                                       output longint unsigned r,
                                       output longint unsigned den);
    int unsigned     size;
    int unsigned     count;
    longint unsigned num;
    size  = eff_size();
    count = eff_count();
    w     = 0;
    w2    = 0;
    r     = 0;
    den   = 1;
    if (count == 0 || idx >= size) return 1'b0;
    if (size > 1) begin
      den = size - 1;
      num = longint'(count - 1) * idx;
      w   = num / den;
      r   = num % den;
    end
    if (w >= count) w = count - 1;
    w2 = (r != 0 && w + 1 < count) ? w + 1 : w;
    return 1'b1;
  endfunction

  function automatic gamma_entry_t gamma_lookup(input logic [EIDX_W-1:0] idx);
    gamma_entry_t       e;
    int unsigned        w;
    int unsigned        w2;
    longint unsigned    r;
    longint unsigned    den;
    longint unsigned    a;
    longint unsigned    b;
    longint unsigned    v;
    logic [POINT_W-1:0] levels;
    e = '0;
    if (!locate_points(idx, w, w2, r, den)) begin
      e.status = (eff_count() == 0) ? ST_NO_POINTS : ST_IDX_ERR;
      return e;
    end
    for (int c = 0; c < 3; c++) begin
      a = curve_mem[w][LEVEL_W*c +: LEVEL_W];
      b = curve_mem[w2][LEVEL_W*c +: LEVEL_W];
      v = (a * (den - r) + b * r) / den;
      if (v > FULL_SCALE) v = FULL_SCALE;
      levels[LEVEL_W*c +: LEVEL_W] = v[LEVEL_W-1:0];
    end
    e = {ST_OK, levels};
    return e;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FULL_SCALE;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic plan_reg(input logic sel, input logic [SIZE_W-1:0] val);
    stim_row_t row;
    row         = '{kind: ROW_SET_REG, default: '0};
    row.reg_sel = sel;
    row.reg_val = val;
    plan.push_back(row);
  endtask

  task automatic plan_write(input logic [PIDX_W-1:0] pidx, input logic [LEVEL_W-1:0] r,
                            input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] b);
    stim_row_t row;
    row       = '{kind: ROW_WRITE, default: '0};
    row.pidx  = pidx;
    row.red   = r;
    row.green = g;
    row.blue  = b;
    plan.push_back(row);
  endtask

  task automatic plan_read(input logic [EIDX_W-1:0] eidx, input bit typed,
                           input logic [STATUS_W-1:0] st, input logic [LEVEL_W-1:0] r,
                           input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] b);
    stim_row_t row;
    row       = '{kind: ROW_READ, default: '0};
    row.eidx  = eidx;
    row.typed = typed;
    row.want  = {st, b, g, r};
    plan.push_back(row);
  endtask

  // Present one item, hold it until taken, then update the predictor
  task automatic offer_item(input logic func, input logic [PIDX_W-1:0] pidx,
                            input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                            input logic [LEVEL_W-1:0] b, input logic [EIDX_W-1:0] eidx,
                            input bit typed, input gamma_entry_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'd0, eidx, b, g, r, pidx};
    do @(posedge clk); while (in_tready !== 1'b1);
    n_sent++;
    if (func == FUNC_WRITE) begin
      curve_mem[pidx] = {b, g, r};
      curve_set[pidx] = 1'b1;
    end else begin
      entry_q.push_back(typed ? want : gamma_lookup(eidx));
    end
  endtask

  // Drop valid, wait for every result, then let a trailing write finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic sel, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    if (sel == REG_LUT_SIZE) lut_reg = val;
    else count_reg = val[COUNT_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [EIDX_W-1:0] e;
    logic [PIDX_W-1:0] p;
    int unsigned       size;
    int unsigned       count;
    int unsigned       w;
    int unsigned       w2;
    longint unsigned   r;
    longint unsigned   den;
    size  = eff_size();
    count = eff_count();
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 9))
        0:       e = $urandom_range(0, 4095);
        1:       e = (size < MAX_LUT_ENTRIES) ? $urandom_range(size, 4095) : 12'd4095;
        2:       e = (size > 0) ? size - 1 : 0;
        default: e = (size > 0) ? $urandom_range(0, size - 1) : $urandom_range(0, 4095);
      endcase
      // Never read a point that is still unset: fill it in first
      if (locate_points(e, w, w2, r, den) && !(curve_set[w] && curve_set[w2])) begin
        p = curve_set[w] ? w2[PIDX_W-1:0] : w[PIDX_W-1:0];
        offer_item(FUNC_WRITE, p, pick_level(), pick_level(), pick_level(),
                   $urandom_range(0, 4095), 1'b0, '0);
      end else begin
        offer_item(FUNC_READ, $urandom_range(0, 255), pick_level(), pick_level(),
                   pick_level(), e, 1'b0, '0);
      end
    end else begin
      p = (count > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, count - 1)
                                                   : $urandom_range(0, 255);
      offer_item(FUNC_WRITE, p, pick_level(), pick_level(), pick_level(),
                 $urandom_range(0, 4095), 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure and in-order comparison
  always @(posedge clk) begin : result_side
    gamma_entry_t got;
    gamma_entry_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid === 1'b1 && out_tready) begin
        got = {out_tuser, out_tdata};
        if (entry_q.size() == 0) begin
          if (fault_cnt < 10)
            $display("unexpected result: status %0d levels %h %h %h",
                     got.status, got.red, got.green, got.blue);
          fault_cnt++;
        end else begin
          want = entry_q.pop_front();
          if (got !== want) begin
            if (fault_cnt < 10)
              $display("mismatch: expected status %0d levels %h %h %h, got status %0d levels %h %h %h",
                       want.status, want.red, want.green, want.blue,
                       got.status, got.red, got.green, got.blue);
            fault_cnt++;
          end
        end
        rx_wait = calm ? 0 : $urandom_range(0, 3);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // Long hold-off on the result side so the block backs up into its input
  initial begin
    wait (n_sent >= HOLD_AFTER);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] lut_val;
    logic [SIZE_W-1:0] cnt_val;
    int unsigned       phase_lut [10];
    int unsigned       phase_cnt [10];
    phase_lut = '{256, 4096, 8191, 2, 1, 0, 3, 4097, 17, 1000};
    phase_cnt = '{256, 511, 256, 2, 1, 40, 0, 300, 5, 129};

    // After reset the count is zero, so every read reports no points
    plan_read(12'd0,    1'b1, ST_NO_POINTS, 16'h0000, 16'h0000, 16'h0000);
    plan_read(12'd4095, 1'b1, ST_NO_POINTS, 16'h0000, 16'h0000, 16'h0000);
    plan_write(8'd0,   16'h0000, 16'h8001, 16'hffff);
    plan_write(8'd1,   16'hffff, 16'hffff, 16'hffff);
    plan_write(8'd2,   16'h1234, 16'h0000, 16'hfedc);
    plan_write(8'd255, 16'hffff, 16'h0001, 16'h0000);
    plan_reg(REG_POINT_COUNT, 13'd2);
    plan_read(12'd0,    1'b1, ST_OK,      16'h0000, 16'h8001, 16'hffff);
    plan_read(12'd255,  1'b1, ST_OK,      16'hffff, 16'hffff, 16'hffff);
    plan_read(12'd256,  1'b1, ST_IDX_ERR, 16'h0000, 16'h0000, 16'h0000);
    plan_read(12'd4095, 1'b1, ST_IDX_ERR, 16'h0000, 16'h0000, 16'h0000);
    plan_read(12'd128,  1'b0, ST_OK,      16'h0000, 16'h0000, 16'h0000);
    plan_read(12'd1,    1'b0, ST_OK,      16'h0000, 16'h0000, 16'h0000);
    // One-entry table returns point 0 as it is
    plan_reg(REG_LUT_SIZE, 13'd1);
    plan_read(12'd0,    1'b1, ST_OK,      16'h0000, 16'h8001, 16'hffff);
    plan_read(12'd1,    1'b1, ST_IDX_ERR, 16'h0000, 16'h0000, 16'h0000);
    plan_reg(REG_LUT_SIZE, 13'd0);
    plan_read(12'd0,    1'b1, ST_IDX_ERR, 16'h0000, 16'h0000, 16'h0000);
    // Oversized table saturates to the largest size
    plan_reg(REG_LUT_SIZE, 13'd8191);
    plan_reg(REG_POINT_COUNT, 13'd3);
    plan_read(12'd4095, 1'b1, ST_OK,      16'h1234, 16'h0000, 16'hfedc);
    plan_read(12'd2047, 1'b0, ST_OK,      16'h0000, 16'h0000, 16'h0000);
    plan_read(12'd0,    1'b1, ST_OK,      16'h0000, 16'h8001, 16'hffff);
    plan_reg(REG_POINT_COUNT, 13'd0);
    plan_read(12'd5,    1'b1, ST_NO_POINTS, 16'h0000, 16'h0000, 16'h0000);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SET_REG: begin
          settle();
          set_register(plan[i].reg_sel, plan[i].reg_val);
        end
        ROW_WRITE:
          offer_item(FUNC_WRITE, plan[i].pidx, plan[i].red, plan[i].green, plan[i].blue,
                     plan[i].eidx, 1'b0, '0);
        default:
          offer_item(FUNC_READ, plan[i].pidx, plan[i].red, plan[i].green, plan[i].blue,
                     plan[i].eidx, plan[i].typed, plan[i].want);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      lut_val = (ph < 10) ? phase_lut[ph] : $urandom_range(0, 8191);
      cnt_val = (ph < 10) ? phase_cnt[ph] : $urandom_range(0, 511);
      set_register(REG_LUT_SIZE, lut_val);
      set_register(REG_POINT_COUNT, cnt_val);
      calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_item();
    end

    in_tvalid <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (entry_q.size() != 0) fault_cnt++;

    if (fault_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
